@@ src/hsts_pkg.sv @@
// Shared types, constants and helpers for the heat stencil time step core.
`timescale 1ns / 1ps
`default_nettype none
package hsts_pkg;

  // Sample format: signed Q8.24
  localparam int VALUE_W = 32;
  // Coefficient format: unsigned Q0.16
  localparam int COEF_W  = 16;
  localparam int STEPS_W = 4;
  // Laplacian right - 2*mid + left, with three guard bits
  localparam int LAP_W   = VALUE_W + 3;
  // Signed coefficient (one zero bit) times laplacian
  localparam int PROD_W  = COEF_W + 1 + LAP_W;
  // Step after the Q0.16 scale-down
  localparam int DELTA_W = PROD_W - COEF_W;
  // mid + delta before saturation
  localparam int SUM_W   = DELTA_W + 1;

  localparam logic [COEF_W-1:0]  COEF_RESET  = COEF_W'(16384);
  localparam logic [STEPS_W-1:0] STEPS_RESET = STEPS_W'(8);
  localparam logic [PROD_W-1:0]  ROUND_BIAS  = PROD_W'(32768);

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  // Register map, one 32-bit word each
  typedef enum logic [1:0] {
    REG_COEFFICIENT    = 2'd0,
    REG_ACTIVE_STEPS   = 2'd1,
    REG_LEFT_BOUNDARY  = 2'd2,
    REG_RIGHT_BOUNDARY = 2'd3
  } reg_idx_t;

  // Window state of one cell
  typedef enum logic [3:0] {
    ST_EMPTY = 4'b0001,
    ST_FIRST = 4'b0010,
    ST_FULL  = 4'b0100,
    ST_FLUSH = 4'b1000
  } win_state_t;

  // Stencil request from window to update stage
  typedef struct packed {
    logic signed [LAP_W-1:0]   lap;
    logic signed [VALUE_W-1:0] mid;
    logic                      last;
  } req_t;

  // Build a request from a three-point window
  function automatic req_t make_req(input logic signed [VALUE_W-1:0] left,
                                    input logic signed [VALUE_W-1:0] mid,
                                    input logic signed [VALUE_W-1:0] right,
                                    input logic last);
    req_t r;
    r.lap  = LAP_W'(left) + LAP_W'(right) - (LAP_W'(mid) <<< 1);
    r.mid  = mid;
    r.last = last;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/hsts_window.sv @@
// Three-point window of one cell: holds the point waiting for its right neighbor.
`timescale 1ns / 1ps
`default_nettype none
module hsts_window (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic signed [hsts_pkg::VALUE_W-1:0] in_sample,
  input  logic                                in_end,
  output logic                                in_stall,
  input  logic signed [hsts_pkg::VALUE_W-1:0] left_bnd,
  input  logic signed [hsts_pkg::VALUE_W-1:0] right_bnd,
  output logic                                req_valid,
  output hsts_pkg::req_t                      req,
  input  logic                                req_ready
);
  import hsts_pkg::*;

  win_state_t                state_r, state_nxt;
  logic signed [VALUE_W-1:0] older_r, older_nxt;
  logic signed [VALUE_W-1:0] newer_r, newer_nxt;
  logic                      req_valid_r, req_valid_nxt;
  req_t                      req_r, req_nxt;
  logic                      ready;
  logic                      accept;
  logic                      emit;

  // Request register may load when empty or draining
  assign ready    = !req_valid_r || req_ready;
  assign in_stall = (state_r == ST_FLUSH) || !ready;
  assign accept   = in_valid && !in_stall;

  // Advance the window and pick the stencil to issue
  always_comb begin
    state_nxt = state_r;
    older_nxt = older_r;
    newer_nxt = newer_r;
    req_nxt   = req_r;
    emit      = 1'b0;
    unique case (state_r)
      ST_EMPTY: begin
        if (accept) begin
          if (in_end) begin
            // single point row sees both boundaries
            emit    = 1'b1;
            req_nxt = make_req(left_bnd, in_sample, right_bnd, 1'b1);
          end else begin
            newer_nxt = in_sample;
            state_nxt = ST_FIRST;
          end
        end
      end
      ST_FIRST, ST_FULL: begin
        if (accept) begin
          emit      = 1'b1;
          req_nxt   = make_req((state_r == ST_FULL) ? older_r : left_bnd,
                               newer_r, in_sample, 1'b0);
          older_nxt = newer_r;
          newer_nxt = in_sample;
          state_nxt = in_end ? ST_FLUSH : ST_FULL;
        end
      end
      ST_FLUSH: begin
        // last point of the row against the right boundary
        if (ready) begin
          emit      = 1'b1;
          req_nxt   = make_req(older_r, newer_r, right_bnd, 1'b1);
          state_nxt = ST_EMPTY;
        end
      end
      default: begin
        state_nxt = ST_EMPTY;
      end
    endcase
  end

  // Hold the request until taken
  always_comb begin
    if (emit) begin
      req_valid_nxt = 1'b1;
    end else if (req_ready) begin
      req_valid_nxt = 1'b0;
    end else begin
      req_valid_nxt = req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EMPTY;
      req_valid_r <= 1'b0;
      older_r     <= '0;
      newer_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      req_valid_r <= req_valid_nxt;
      older_r     <= older_nxt;
      newer_r     <= newer_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
  end

  assign req_valid = req_valid_r;
  assign req       = req_r;

endmodule
`default_nettype wire

@@ src/hsts_update.sv @@
// Two-stage update of one cell: scale the laplacian, then round, add and saturate.
`timescale 1ns / 1ps
`default_nettype none
module hsts_update (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                req_valid,
  input  hsts_pkg::req_t                      req,
  output logic                                req_ready,
  input  logic [hsts_pkg::COEF_W-1:0]         coef,
  output logic                                out_valid,
  output logic signed [hsts_pkg::VALUE_W-1:0] out_value,
  output logic                                out_end,
  input  logic                                out_stall
);
  import hsts_pkg::*;

  logic                      prod_valid_r;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [VALUE_W-1:0] prod_mid_r;
  logic                      prod_end_r;
  logic                      res_valid_r;
  logic signed [VALUE_W-1:0] res_value_r, res_value_nxt;
  logic                      res_end_r;
  logic                      res_ready;
  logic                      prod_ready;
  logic signed [PROD_W-1:0]  biased;
  logic signed [DELTA_W-1:0] delta;
  logic signed [SUM_W-1:0]   sum;

  assign res_ready  = !res_valid_r || !out_stall;
  assign prod_ready = !prod_valid_r || res_ready;
  assign req_ready  = prod_ready;

  // Scale the laplacian by r
  assign prod_nxt = PROD_W'($signed({1'b0, coef})) * PROD_W'(req.lap);

  // Round half up to Q8.24, add, saturate on overflow
  assign biased = prod_r + $signed(ROUND_BIAS);
  assign delta  = biased[PROD_W-1:COEF_W];
  assign sum    = SUM_W'(prod_mid_r) + SUM_W'(delta);

  always_comb begin
    if (sum[SUM_W-1:VALUE_W-1] == {(SUM_W-VALUE_W+1){1'b0}} ||
        sum[SUM_W-1:VALUE_W-1] == {(SUM_W-VALUE_W+1){1'b1}}) begin
      res_value_nxt = sum[VALUE_W-1:0];
    end else if (sum[SUM_W-1]) begin
      res_value_nxt = VALUE_MIN;
    end else begin
      res_value_nxt = VALUE_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid_r <= req_valid;
      end
      if (res_ready) begin
        res_valid_r <= prod_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && req_valid) begin
      prod_r     <= prod_nxt;
      prod_mid_r <= req.mid;
      prod_end_r <= req.last;
    end
    if (res_ready && prod_valid_r) begin
      res_value_r <= res_value_nxt;
      res_end_r   <= prod_end_r;
    end
  end

  assign out_valid = res_valid_r;
  assign out_value = res_value_r;
  assign out_end   = res_end_r;

endmodule
`default_nettype wire

@@ src/hsts_cell.sv @@
// One time-step cell: window followed by the update pipeline.
`timescale 1ns / 1ps
`default_nettype none
module hsts_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic signed [hsts_pkg::VALUE_W-1:0] in_sample,
  input  logic                                in_end,
  output logic                                in_stall,
  input  logic [hsts_pkg::COEF_W-1:0]         coef,
  input  logic signed [hsts_pkg::VALUE_W-1:0] left_bnd,
  input  logic signed [hsts_pkg::VALUE_W-1:0] right_bnd,
  output logic                                out_valid,
  output logic signed [hsts_pkg::VALUE_W-1:0] out_value,
  output logic                                out_end,
  input  logic                                out_stall
);
  import hsts_pkg::*;

  logic req_valid;
  req_t req;
  logic req_ready;

  hsts_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_sample (in_sample),
    .in_end    (in_end),
    .in_stall  (in_stall),
    .left_bnd  (left_bnd),
    .right_bnd (right_bnd),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready)
  );

  hsts_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready),
    .coef      (coef),
    .out_valid (out_valid),
    .out_value (out_value),
    .out_end   (out_end),
    .out_stall (out_stall)
  );

endmodule
`default_nettype wire

@@ src/heat_stencil_time_step_core.sv @@
// Top level: register port and a chain of STAGES explicit heat-equation cells.
// Each cell has three register stages (window request, product, result): a point enters a
// cell's window request register once its right neighbor or the row end reaches the cell,
// then passes the product and result registers. Within a row one point is taken per cycle
// while out_stall is low; each cell stalls its feeder at every row end to issue the last
// point. Synchronous active-low reset empties all windows.
`timescale 1ns / 1ps
`default_nettype none
module heat_stencil_time_step_core #(
  parameter int STAGES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [hsts_pkg::VALUE_W-1:0] in_sample,
  input  logic                                in_row_end,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [hsts_pkg::VALUE_W-1:0] out_result,
  output logic                                out_result_end,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import hsts_pkg::*;

  logic [COEF_W-1:0]         coefficient_r;
  logic [STEPS_W-1:0]        active_steps_r;
  logic signed [VALUE_W-1:0] left_boundary_r;
  logic signed [VALUE_W-1:0] right_boundary_r;
  reg_idx_t                  reg_idx;
  logic                      wr_en;

  logic                      chain_valid [STAGES+1];
  logic signed [VALUE_W-1:0] chain_value [STAGES+1];
  logic                      chain_end   [STAGES+1];
  logic                      chain_stall [STAGES+1];

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coefficient_r    <= COEF_RESET;
      active_steps_r   <= STEPS_RESET;
      left_boundary_r  <= '0;
      right_boundary_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_COEFFICIENT:    coefficient_r    <= pwdata[COEF_W-1:0];
        REG_ACTIVE_STEPS:   active_steps_r   <= pwdata[STEPS_W-1:0];
        REG_LEFT_BOUNDARY:  left_boundary_r  <= pwdata[VALUE_W-1:0];
        REG_RIGHT_BOUNDARY: right_boundary_r <= pwdata[VALUE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      REG_COEFFICIENT:    prdata = 32'(coefficient_r);
      REG_ACTIVE_STEPS:   prdata = 32'(active_steps_r);
      REG_LEFT_BOUNDARY:  prdata = 32'(left_boundary_r);
      REG_RIGHT_BOUNDARY: prdata = 32'(right_boundary_r);
      default:            prdata = '0;
    endcase
  end

  // Feed the chain
  assign chain_valid[0] = in_valid;
  assign chain_value[0] = in_sample;
  assign chain_end[0]   = in_row_end;
  assign in_stall       = chain_stall[0];

  // Cells beyond active_steps use r = 0 and pass points through
  for (genvar c = 0; c < STAGES; c++) begin : g_cell
    logic [COEF_W-1:0] cell_coef;

    assign cell_coef = (32'(c) < 32'(active_steps_r)) ? coefficient_r : '0;

    hsts_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[c]),
      .in_sample (chain_value[c]),
      .in_end    (chain_end[c]),
      .in_stall  (chain_stall[c]),
      .coef      (cell_coef),
      .left_bnd  (left_boundary_r),
      .right_bnd (right_boundary_r),
      .out_valid (chain_valid[c+1]),
      .out_value (chain_value[c+1]),
      .out_end   (chain_end[c+1]),
      .out_stall (chain_stall[c+1])
    );
  end

  // Drain the chain
  assign chain_stall[STAGES] = out_stall;
  assign out_valid           = chain_valid[STAGES];
  assign out_result          = chain_value[STAGES];
  assign out_result_end      = chain_end[STAGES];

endmodule
`default_nettype wire
